FILE: design/ssq_pkg.sv
// Shared types and constants for the servo scan sequencer.
// Used by every module of the block; depends on nothing.
package ssq_pkg;

	localparam int ANGLE_REGS = 5;
	localparam int ADDR_W     = 5;

	localparam logic [31:0] SETTLE_RESET = 32'd1000;
	localparam logic [ANGLE_REGS-1:0][7:0] ANGLE_RESET =
		{8'd150, 8'd120, 8'd90, 8'd60, 8'd30};

	typedef enum logic [2:0] {
		REG_SETTLE = 3'd0,
		REG_ANGLE0 = 3'd1,
		REG_ANGLE1 = 3'd2,
		REG_ANGLE2 = 3'd3,
		REG_ANGLE3 = 3'd4,
		REG_ANGLE4 = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_SERVO_ERR = 2'd1,
		ST_READ_ERR  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SNAP_NONE     = 2'd0,
		SNAP_PROGRESS = 2'd1,
		SNAP_SUMMARY  = 2'd2
	} snapshot_t;

	typedef enum logic {
		PH_SET    = 1'b0,
		PH_SETTLE = 1'b1
	} phase_t;

	typedef struct packed {
		logic [31:0]                 settle_ticks;
		logic [ANGLE_REGS-1:0][7:0]  angle;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_tick;
		logic        servo_ack;
		logic [7:0]  servo_angle_now;
		logic        sensor_ok;
		logic        detect_ok;
		logic        human_seen;
	} poll_t;

	typedef struct packed {
		status_t     status;
		snapshot_t   snapshot;
		logic [7:0]  angle_command;
		logic        command_valid;
		logic [2:0]  point_index;
		logic [7:0]  angle_readback;
		logic        servo_valid;
		logic        point_usable;
		logic        summary_valid;
		logic        summary_human;
	} res_t;

endpackage

FILE: design/ssq_cfg.sv
// APB register file of the servo scan sequencer: settle time and five angles.
// Depends on ssq_pkg.
module ssq_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ssq_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output ssq_pkg::cfg_t              cfg
);
	import ssq_pkg::*;

	logic [31:0]                settle_q;
	logic [ANGLE_REGS-1:0][7:0] angle_q;
	logic                       wr_en;
	reg_idx_t                   sel;

	assign wr_en = psel & penable & pwrite;
	assign sel   = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_RESET;
			angle_q  <= ANGLE_RESET;
		end else if (wr_en) begin
			unique case (sel)
				REG_SETTLE: settle_q   <= pwdata;
				REG_ANGLE0: angle_q[0] <= pwdata[7:0];
				REG_ANGLE1: angle_q[1] <= pwdata[7:0];
				REG_ANGLE2: angle_q[2] <= pwdata[7:0];
				REG_ANGLE3: angle_q[3] <= pwdata[7:0];
				REG_ANGLE4: angle_q[4] <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_SETTLE: prdata = settle_q;
			REG_ANGLE0: prdata = {24'd0, angle_q[0]};
			REG_ANGLE1: prdata = {24'd0, angle_q[1]};
			REG_ANGLE2: prdata = {24'd0, angle_q[2]};
			REG_ANGLE3: prdata = {24'd0, angle_q[3]};
			REG_ANGLE4: prdata = {24'd0, angle_q[4]};
			default:    prdata = 32'd0;
		endcase
	end

	assign cfg.settle_ticks = settle_q;
	assign cfg.angle        = angle_q;

endmodule

FILE: design/ssq_core.sv
// Scan state and per-poll decision logic of the servo scan sequencer.
// Depends on ssq_pkg.
module ssq_core #(
	parameter int POINTS = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  ssq_pkg::poll_t poll,
	input  ssq_pkg::cfg_t  cfg,
	output ssq_pkg::res_t  res
);
	import ssq_pkg::*;

	phase_t              phase_q, phase_d;
	logic [2:0]          scan_q, scan_d;
	logic [31:0]         wait_start_q, wait_start_d;
	logic [POINTS-1:0]   ok_q, ok_d, person_q, person_d;
	logic [7:0]          last_angle_q, last_angle_d;
	logic                servo_good_q, servo_good_d;
	logic                round_valid_q, round_valid_d;
	logic                round_human_q, round_human_d;

	logic [2:0]  idx;
	logic        set_ph, clear, servo_fail, commit, read_pt, pv, last_pt;
	logic [31:0] start, elapsed;

	// Shared decode of the current poll.
	always_comb begin
		idx        = (scan_q >= 3'(POINTS)) ? 3'd0 : scan_q;
		set_ph     = (phase_q == PH_SET);
		clear      = set_ph && (idx == 3'd0);
		servo_fail = set_ph && !poll.servo_ack;
		commit     = set_ph && poll.servo_ack;
		start      = set_ph ? poll.now_tick : wait_start_q;
		elapsed    = poll.now_tick - start;
		read_pt    = !servo_fail && (elapsed >= cfg.settle_ticks);
		pv         = read_pt && poll.sensor_ok && poll.detect_ok;
		last_pt    = (idx == 3'(POINTS - 1));
	end

	// Phase next state.
	always_comb begin
		phase_d = phase_q;
		if (read_pt) begin
			phase_d = PH_SET;
		end else if (commit) begin
			phase_d = PH_SETTLE;
		end
	end

	// Data state updates and the result word.
	always_comb begin
		ok_d          = clear ? '0 : ok_q;
		person_d      = clear ? '0 : person_q;
		round_valid_d = clear ? 1'b0 : round_valid_q;
		round_human_d = clear ? 1'b0 : round_human_q;
		for (int i = 0; i < POINTS; i++) begin
			if (idx == 3'(i)) begin
				if (read_pt) begin
					ok_d[i]     = pv;
					person_d[i] = poll.human_seen;
				end else if (commit) begin
					ok_d[i] = 1'b0;
				end
			end
		end
		if (read_pt && last_pt) begin
			round_valid_d = |ok_d;
			round_human_d = |(ok_d & person_d);
		end

		wait_start_d = commit ? poll.now_tick : wait_start_q;
		last_angle_d = commit ? poll.servo_angle_now : last_angle_q;
		servo_good_d = set_ph ? poll.servo_ack : servo_good_q;

		if (read_pt) begin
			scan_d = last_pt ? 3'd0 : idx + 3'd1;
		end else begin
			scan_d = idx;
		end

		if (servo_fail) begin
			res.status = ST_SERVO_ERR;
		end else if (read_pt && !pv) begin
			res.status = ST_READ_ERR;
		end else begin
			res.status = ST_OK;
		end

		if (read_pt) begin
			res.snapshot = last_pt ? SNAP_SUMMARY : SNAP_PROGRESS;
		end else if (clear) begin
			res.snapshot = SNAP_PROGRESS;
		end else begin
			res.snapshot = SNAP_NONE;
		end

		res.angle_command  = set_ph ? cfg.angle[idx] : 8'd0;
		res.command_valid  = set_ph;
		res.point_index    = idx;
		res.angle_readback = last_angle_d;
		res.servo_valid    = servo_good_d;
		res.point_usable   = pv;
		res.summary_valid  = round_valid_d;
		res.summary_human  = round_human_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SET;
			scan_q        <= 3'd0;
			wait_start_q  <= 32'd0;
			ok_q          <= '0;
			person_q      <= '0;
			last_angle_q  <= 8'd0;
			servo_good_q  <= 1'b0;
			round_valid_q <= 1'b0;
			round_human_q <= 1'b0;
		end else if (take) begin
			phase_q       <= phase_d;
			scan_q        <= scan_d;
			wait_start_q  <= wait_start_d;
			ok_q          <= ok_d;
			person_q      <= person_d;
			last_angle_q  <= last_angle_d;
			servo_good_q  <= servo_good_d;
			round_valid_q <= round_valid_d;
			round_human_q <= round_human_d;
		end
	end

endmodule

FILE: design/ssq_outq.sv
// Two-word result buffer: a result register plus a skid slot.
// Depends on ssq_pkg.
module ssq_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ssq_pkg::res_t din,
	output logic          full,
	output logic          res_valid,
	input  logic          res_ready,
	output ssq_pkg::res_t dout
);
	import ssq_pkg::*;

	res_t       head_q, tail_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = res_valid & res_ready;
	assign res_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign dout      = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// The head is refilled from the skid slot when it drains while full,
	// or straight from the core when it drains or is empty.
	always_ff @(posedge clk) begin
		if (pop && cnt_q == 2'd2) begin
			head_q <= tail_q;
		end else if (push && (cnt_q == 2'd0 || pop)) begin
			head_q <= din;
		end
		if (push && cnt_q == 2'd1 && !pop) begin
			tail_q <= din;
		end
	end

endmodule

FILE: design/servo_scan_sequencer.sv
// Servo scan sequencer: takes one poll word per clock cycle while poll_ready is
// high and returns exactly one result word per poll, in order. The scan state is
// updated in the cycle a poll is accepted, and its result word is registered into
// the result buffer. Sustained throughput is one poll per cycle whenever the result
// side keeps taking words. A two-word result buffer lets a poll be taken while a
// finished result still waits; poll_ready drops only when both words are held. Each
// poll runs through one 32-bit wrapping subtract and compare against settle_ticks,
// which is the longest path. Settle time and the five point angles are written
// through the APB port; the user must write them only while the block is idle, as
// the block does not enforce it. Depends on ssq_pkg, ssq_cfg, ssq_core and ssq_outq.
module servo_scan_sequencer #(
	parameter int POINTS = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ssq_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,

	input  logic                       poll_valid,
	output logic                       poll_ready,
	input  logic [31:0]                now_tick,
	input  logic                       servo_ack,
	input  logic [7:0]                 servo_angle_now,
	input  logic                       sensor_ok,
	input  logic                       detect_ok,
	input  logic                       human_seen,

	output logic                       res_valid,
	input  logic                       res_ready,
	output logic [1:0]                 status,
	output logic [1:0]                 snapshot,
	output logic [7:0]                 angle_command,
	output logic                       command_valid,
	output logic [2:0]                 point_index,
	output logic [7:0]                 angle_readback,
	output logic                       servo_valid,
	output logic                       point_usable,
	output logic                       summary_valid,
	output logic                       summary_human
);
	import ssq_pkg::*;

	cfg_t  cfg;
	poll_t poll;
	res_t  core_res, out_res;
	logic  take, full;

	// The port never stalls a register access.
	assign pready = 1'b1;

	assign poll.now_tick        = now_tick;
	assign poll.servo_ack       = servo_ack;
	assign poll.servo_angle_now = servo_angle_now;
	assign poll.sensor_ok       = sensor_ok;
	assign poll.detect_ok       = detect_ok;
	assign poll.human_seen      = human_seen;

	// A poll is taken whenever the result buffer has a free word.
	assign poll_ready = !full;
	assign take       = poll_valid & poll_ready;

	ssq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	ssq_core #(
		.POINTS (POINTS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.poll   (poll),
		.cfg    (cfg),
		.res    (core_res)
	);

	ssq_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.din       (core_res),
		.full      (full),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.dout      (out_res)
	);

	assign status         = out_res.status;
	assign snapshot       = out_res.snapshot;
	assign angle_command  = out_res.angle_command;
	assign command_valid  = out_res.command_valid;
	assign point_index    = out_res.point_index;
	assign angle_readback = out_res.angle_readback;
	assign servo_valid    = out_res.servo_valid;
	assign point_usable   = out_res.point_usable;
	assign summary_valid  = out_res.summary_valid;
	assign summary_human  = out_res.summary_human;

endmodule

FILE: design/ssq_checker.sv
// Port-level checks for the servo scan sequencer, bound to the top level.
// Depends on ssq_pkg and servo_scan_sequencer.
module ssq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       poll_valid,
	input logic       poll_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] status,
	input logic [1:0] snapshot,
	input logic       command_valid,
	input logic       servo_valid,
	input logic       point_usable
);
	import ssq_pkg::*;

	// A result word that is not taken stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its status and snapshot.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(status) && $stable(snapshot))
		else $error("stalled result word changed");

	// Every accepted poll leaves a result word offered in the next cycle.
	a_poll_result: assert property (@(posedge clk) disable iff (!arst_n)
		poll_valid && poll_ready |=> res_valid)
		else $error("accepted poll produced no result word");

	// The poll side stalls only while results are waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!poll_ready |-> res_valid)
		else $error("poll side stalled with an empty result buffer");

	// A servo error comes only from a command step and clears the servo flag.
	a_servo_err: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_SERVO_ERR |->
			command_valid && !servo_valid && !point_usable
			&& snapshot != SNAP_SUMMARY)
		else $error("inconsistent servo error word");

endmodule

bind servo_scan_sequencer ssq_checker u_ssq_checker (.*);
